>>> src/byte_aligned_gamma_decoder_core_assert.svh
// Assertion macros shared by the decoder RTL.
// Each macro takes a label, the clock, the active-low reset and a property expression.
`ifndef BYTE_ALIGNED_GAMMA_DECODER_CORE_ASSERT_SVH
`define BYTE_ALIGNED_GAMMA_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define BAGD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("bagd assertion failed");

`define BAGD_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("bagd forbidden condition seen");

`else

`define BAGD_ASSERT(lbl, clk, rstn, prop)
`define BAGD_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> src/bagd_pkg.sv
`default_nettype none

package bagd_pkg;

	localparam int MAX_PREFIX_DEFAULT = 31;
	localparam int ValueW = 32;
	localparam int ByteW = 8;

	localparam logic [ValueW-1:0] ACC_RESET = ValueW'(1);

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_PREFIX_ERR = 1'b1;

	typedef struct packed {
		logic emit;
		logic status;
		logic [ValueW-1:0] value;
	} scan_res_t;

endpackage

`default_nettype wire

>>> src/bagd_scan.sv
`default_nettype none

module bagd_scan #(
	parameter int MaxPrefix = bagd_pkg::MAX_PREFIX_DEFAULT,
	parameter int CntW = $clog2(MaxPrefix + 1)
) (
	input  wire logic [bagd_pkg::ByteW-1:0]  code_byte,
	input  wire logic                        in_payload,
	input  wire logic [CntW-1:0]             bit_count,
	input  wire logic [bagd_pkg::ValueW-1:0] accumulator,
	output      logic                        in_payload_nx,
	output      logic [CntW-1:0]             bit_count_nx,
	output      logic [bagd_pkg::ValueW-1:0] accumulator_nx,
	output      bagd_pkg::scan_res_t         res
);

	logic                        p;
	logic [CntW-1:0]             c;
	logic [bagd_pkg::ValueW-1:0] acc;
	logic                        done;
	logic                        b;

	// Walk the byte MSB first; stop at the first bit that ends a code.
	always_comb begin
		p = in_payload;
		c = bit_count;
		acc = accumulator;
		done = 1'b0;
		b = 1'b0;
		res.emit = 1'b0;
		res.status = bagd_pkg::STATUS_OK;
		res.value = '0;
		for (int k = bagd_pkg::ByteW - 1; k >= 0; k--) begin
			b = code_byte[k];
			if (!done) begin
				if (!p) begin
					if (b) begin
						if (c >= CntW'(MaxPrefix)) begin
							done = 1'b1;
							res.emit = 1'b1;
							res.status = bagd_pkg::STATUS_PREFIX_ERR;
							res.value = '0;
						end else begin
							c = c + CntW'(1);
						end
					end else begin
						p = 1'b1;
						if (c == '0) begin
							done = 1'b1;
							res.emit = 1'b1;
							res.value = acc;
						end
					end
				end else begin
					acc = {acc[bagd_pkg::ValueW-2:0], b};
					if (c != '0)
						c = c - CntW'(1);
					if (c == '0) begin
						done = 1'b1;
						res.emit = 1'b1;
						res.value = acc;
					end
				end
			end
		end
		// A finished code (or an error) drops the rest of the byte and restarts.
		if (res.emit) begin
			in_payload_nx = 1'b0;
			bit_count_nx = '0;
			accumulator_nx = bagd_pkg::ACC_RESET;
		end else begin
			in_payload_nx = p;
			bit_count_nx = c;
			accumulator_nx = acc;
		end
	end

endmodule

`default_nettype wire

>>> src/byte_aligned_gamma_decoder_core.sv
// Byte-aligned Elias gamma decoder.
// Input channel: code_byte with in_valid/in_ready, one stream byte per item, bits
// taken MSB first. Each code starts on a fresh byte; bits after a code's end are dropped.
// Output channel: decoded_value and status with out_valid/out_ready. A byte that
// completes a code yields one item; other bytes yield none. status high means the
// prefix ran past MaxPrefix ones: decoded_value is then 0 and the decoder restarts.
// Timing: an accepted byte is held in an input register, where the 8-bit scan
// runs against the decoder state; its result is registered in the output register
// that drives out_valid. A byte can be taken every cycle while the output does not
// stall; the throughput is one item per cycle, set by the combinational scan.
// Stall: the output register holds its item until out_ready. While it is full and
// not taken, a byte that would complete a code waits in the input register and
// in_ready drops; bytes that complete nothing still flow.
// Reset: arst_n clears both registers and puts the decoder at the start of a code.
`default_nettype none

`include "byte_aligned_gamma_decoder_core_assert.svh"

module byte_aligned_gamma_decoder_core #(
	parameter int MaxPrefix = bagd_pkg::MAX_PREFIX_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic [bagd_pkg::ByteW-1:0]  code_byte,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [bagd_pkg::ValueW-1:0] decoded_value,
	output      logic                        status
);

	localparam int CntW = $clog2(MaxPrefix + 1);

	logic                        valid_s1;
	logic [bagd_pkg::ByteW-1:0]  code_s1;
	logic                        in_payload_q;
	logic [CntW-1:0]             bit_count_q;
	logic [bagd_pkg::ValueW-1:0] accumulator_q;
	logic                        out_valid_q;
	logic [bagd_pkg::ValueW-1:0] value_q;
	logic                        status_q;

	logic                        in_payload_nx;
	logic [CntW-1:0]             bit_count_nx;
	logic [bagd_pkg::ValueW-1:0] accumulator_nx;
	bagd_pkg::scan_res_t         res;
	logic                        out_free;
	logic                        adv_s1;

	bagd_scan #(
		.MaxPrefix(MaxPrefix),
		.CntW(CntW)
	) u_scan (
		.code_byte(code_s1),
		.in_payload(in_payload_q),
		.bit_count(bit_count_q),
		.accumulator(accumulator_q),
		.in_payload_nx(in_payload_nx),
		.bit_count_nx(bit_count_nx),
		.accumulator_nx(accumulator_nx),
		.res(res)
	);

	assign out_free = !out_valid_q || out_ready;
	// Hold the byte only when it makes an item and the output is still occupied.
	assign adv_s1 = valid_s1 && (!res.emit || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1 <= code_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			bit_count_q <= '0;
			accumulator_q <= bagd_pkg::ACC_RESET;
		end else if (adv_s1) begin
			in_payload_q <= in_payload_nx;
			bit_count_q <= bit_count_nx;
			accumulator_q <= accumulator_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.emit) begin
			value_q <= res.value;
			status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign decoded_value = value_q;
	assign status = status_q;

	`BAGD_ASSERT(a_err_zero, clk, arst_n, (out_valid_q && status_q == bagd_pkg::STATUS_PREFIX_ERR) |-> (value_q == '0))
	`BAGD_ASSERT(a_ok_nonzero, clk, arst_n, (out_valid_q && status_q == bagd_pkg::STATUS_OK) |-> (value_q != '0))
	`BAGD_ASSERT_NEVER(a_cnt_range, clk, arst_n, bit_count_q > CntW'(MaxPrefix))
	`BAGD_ASSERT(a_payload_cnt, clk, arst_n, in_payload_q |-> (bit_count_q != '0))

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int MAX_PREFIX = bagd_pkg::MAX_PREFIX_DEFAULT;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [bagd_pkg::ValueW-1:0] value;
		logic                        status;
	} gamma_result_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [bagd_pkg::ByteW-1:0]  code_byte = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [bagd_pkg::ValueW-1:0] decoded_value;
	logic                        status;

	logic [bagd_pkg::ByteW-1:0] pending_bytes[$];
	gamma_result_t              expected_codes[$];
	int                         mismatches = 0;
	int                         bytes_taken = 0;
	logic                       sink_hold = 1'b0;

	// decoder state mirrored from the block
	logic                        dec_in_payload = 1'b0;
	logic [5:0]                  dec_count = '0;
	logic [bagd_pkg::ValueW-1:0] dec_acc = bagd_pkg::ACC_RESET;

	byte_aligned_gamma_decoder_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.code_byte    (code_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.decoded_value(decoded_value),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void queue_byte(input logic [bagd_pkg::ByteW-1:0] cb);
		pending_bytes.insert(pending_bytes.size(), cb);
	endfunction

	function automatic void queue_expect(input logic [bagd_pkg::ValueW-1:0] val,
			input logic st);
		gamma_result_t r;
		r.value = val;
		r.status = st;
		expected_codes.insert(expected_codes.size(), r);
	endfunction

	function automatic void restart_decoder();
		dec_in_payload = 1'b0;
		dec_count = '0;
		dec_acc = bagd_pkg::ACC_RESET;
	endfunction

	// Walk one byte MSB first; return 1 when it finishes a code or trips the prefix limit.
	function automatic bit decode_byte(input logic [bagd_pkg::ByteW-1:0] cb,
			output logic [bagd_pkg::ValueW-1:0] val, output logic st);
		logic cur;
		val = '0;
		st = bagd_pkg::STATUS_OK;
		for (int k = bagd_pkg::ByteW - 1; k >= 0; k--) begin
			cur = cb[k];
			if (!dec_in_payload) begin
				if (cur) begin
					if (dec_count >= MAX_PREFIX) begin
						val = '0;
						st = bagd_pkg::STATUS_PREFIX_ERR;
						restart_decoder();
						return 1'b1;
					end
					dec_count = dec_count + 6'd1;
				end else begin
					dec_in_payload = 1'b1;
					if (dec_count == 0) begin
						val = dec_acc;
						restart_decoder();
						return 1'b1;
					end
				end
			end else begin
				dec_acc = {dec_acc[bagd_pkg::ValueW-2:0], cur};
				if (dec_count > 0)
					dec_count = dec_count - 6'd1;
				if (dec_count == 0) begin
					val = dec_acc;
					restart_decoder();
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	// Encode n prefix ones, a zero, n payload bits; pad the last byte with random bits.
	function automatic void push_code(input int n, input logic [31:0] payload);
		logic [71:0] v;
		int nb;
		v[71:40] = $urandom;
		v[39:8] = $urandom;
		v[7:0] = 8'($urandom);
		for (int i = 0; i < n; i++)
			v[71-i] = 1'b1;
		v[71-n] = 1'b0;
		for (int j = 0; j < n; j++)
			v[70-n-j] = payload[n-1-j];
		nb = (2 * n + 8) / 8;
		for (int i = 0; i < nb; i++)
			queue_byte(v[71-8*i -: 8]);
	endfunction

	always @(posedge clk or negedge arst_n) begin : byte_source
		logic [bagd_pkg::ValueW-1:0] v;
		logic                        s;
		int                          gap;
		bit                          burst;
		if (!arst_n) begin
			in_valid <= 1'b0;
			code_byte <= '0;
			gap = 0;
			burst = 1'b0;
			restart_decoder();
		end else begin
			if (in_valid && in_ready) begin
				if (decode_byte(code_byte, v, s))
					queue_expect(v, s);
				bytes_taken++;
				if ($urandom_range(0, 39) == 0)
					burst = !burst;
				gap = burst ? 0 : $urandom_range(0, 11);
			end
			// a free slot: either idle out the gap or offer the next item
			if (!in_valid || in_ready) begin
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					in_valid <= 1'b1;
					code_byte <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_sink
		gamma_result_t exp_res;
		int            wait_cnt;
		bit            burst;
		if (!arst_n) begin
			out_ready <= 1'b0;
			wait_cnt = 0;
			burst = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_codes.size() == 0) begin
					$error("unexpected item: decoded_value %h status %b", decoded_value, status);
					mismatches++;
				end else begin
					exp_res = expected_codes.pop_front();
					if (decoded_value !== exp_res.value) begin
						$error("decoded_value: expected %h, got %h", exp_res.value, decoded_value);
						mismatches++;
					end
					if (status !== exp_res.status) begin
						$error("status: expected %b, got %b", exp_res.status, status);
						mismatches++;
					end
				end
				if ($urandom_range(0, 29) == 0)
					burst = !burst;
				wait_cnt = burst ? 0 : $urandom_range(0, 11);
			end
			if (sink_hold) begin
				out_ready <= 1'b0;
			end else if (wait_cnt > 0) begin
				wait_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stall the output long enough that the block backs up into its input.
	initial begin
		wait (bytes_taken >= 120);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	initial begin : stimulus
		int base;
		int r;
		int n;
		// empty prefix, short codes, leftover bits
		queue_byte(8'h00);
		queue_byte(8'h80);
		queue_byte(8'hEF);
		// codes spanning two bytes
		queue_byte(8'hF0);
		queue_byte(8'hA5);
		queue_byte(8'hFE);
		queue_byte(8'hFF);
		// longest legal prefix: all-ones and all-zeros payload
		push_code(MAX_PREFIX, 32'hFFFF_FFFF);
		push_code(MAX_PREFIX, 32'h0);
		// overlong prefix, then recovery
		repeat (4) queue_byte(8'hFF);
		queue_byte(8'h00);

		base = pending_bytes.size();
		while (pending_bytes.size() < base + 400) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				r = $urandom_range(0, 9);
				if (r < 7)
					n = $urandom_range(0, 6);
				else if (r < 9)
					n = $urandom_range(7, 20);
				else
					n = $urandom_range(21, MAX_PREFIX);
				push_code(n, $urandom);
			end else if (r < 92) begin
				queue_byte(8'($urandom_range(0, 255)));
			end else begin
				repeat (4) queue_byte(8'hFF);
			end
		end

		do @(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_codes.size() != 0);
		repeat (20) @(negedge clk);
		if (expected_codes.size() != 0) begin
			$error("%0d expected items never arrived", expected_codes.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/bagd_pkg.sv
src/bagd_scan.sv
src/byte_aligned_gamma_decoder_core.sv
tb/sv/tb.sv
